### rtl/fmr_pkg.sv
// ----------------------------------------------------------------------------
// fmr_pkg
// Shared types, codes and command name tables of the framed message receiver.
// ----------------------------------------------------------------------------
package fmr_pkg;

	localparam int PAYLOAD_MAX_DEF = 32;
	localparam int DATA_MAX_DEF    = 32;

	localparam int CFG_W = 16;

	localparam logic [7:0]  START_CODE_RST    = 8'd2;
	localparam logic [7:0]  END_CODE_RST      = 8'd3;
	localparam logic [5:0]  MAX_LENGTH_RST    = 6'd32;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

	localparam logic [7:0]  CHAR_MIN = 8'd32;
	localparam logic [7:0]  CHAR_MAX = 8'd126;
	localparam logic [7:0]  CHAR_SEP = 8'h7C;
	localparam logic [7:0]  CHAR_0   = 8'h30;
	localparam logic [7:0]  CHAR_9   = 8'h39;
	localparam logic [19:0] ID_MAX   = 20'd65535;

	localparam int         NUM_CMDS = 8;
	localparam logic [3:0] CMD_NONE = 4'd8;
	localparam logic [3:0] NAME_POS_MAX = 4'd15;

	typedef enum logic [1:0] {
		CFG_START_CODE    = 2'd0,
		CFG_END_CODE      = 2'd1,
		CFG_MAX_LENGTH    = 2'd2,
		CFG_TIMEOUT_TICKS = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		STAT_OK          = 3'd0,
		STAT_BAD_LEN     = 3'd1,
		STAT_BAD_CHAR    = 3'd2,
		STAT_BAD_CHK     = 3'd3,
		STAT_BAD_FMT     = 3'd4,
		STAT_UNKNOWN_CMD = 3'd5,
		STAT_TIMEOUT     = 3'd6
	} stat_t;

	typedef enum logic [1:0] {
		FLD_ID   = 2'd0,
		FLD_CMD  = 2'd1,
		FLD_DATA = 2'd2
	} field_t;

	typedef enum logic [2:0] {
		ST_WAIT_START = 3'd0,
		ST_LEN        = 3'd1,
		ST_PAYLOAD    = 3'd2,
		ST_CHK        = 3'd3,
		ST_END        = 3'd4,
		ST_DRAIN      = 3'd5
	} ctrl_state_t;

	typedef struct packed {
		logic  clr_frame;
		logic  set_len;
		logic  take_byte;
		logic  tick_inc;
		logic  idle_clr;
		logic  drain_step;
		logic  out_load;
		logic  out_data;
		stat_t out_code;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_start;
		logic len_bad;
		logic printable;
		logic payload_done;
		logic xor_ok;
		logic end_ok;
		logic timed_out;
		logic frame_ok;
		logic cmd_found;
		logic data_empty;
		logic drain_done;
		logic out_free;
	} dp_stat_t;

	// names left aligned, padding never compared
	function automatic logic [7:0] cmd_char(input logic [2:0] idx, input logic [2:0] pos);
		logic [63:0] n;
		unique case (idx)
			3'd0: n = "OK      ";
			3'd1: n = "UID     ";
			3'd2: n = "REQ_PIN ";
			3'd3: n = "PIN     ";
			3'd4: n = "ERR     ";
			3'd5: n = "TIMEOUT ";
			3'd6: n = "LOCKED  ";
			default: n = "NACK    ";
		endcase
		return n[63 - 8 * pos -: 8];
	endfunction

	function automatic logic [3:0] cmd_len(input logic [2:0] idx);
		logic [3:0] l;
		unique case (idx)
			3'd0: l = 4'd2;
			3'd1: l = 4'd3;
			3'd2: l = 4'd7;
			3'd3: l = 4'd3;
			3'd4: l = 4'd3;
			3'd5: l = 4'd7;
			3'd6: l = 4'd6;
			default: l = 4'd4;
		endcase
		return l;
	endfunction

endpackage

### rtl/fmr_ctrl.sv
// ----------------------------------------------------------------------------
// fmr_ctrl
// Frame phase state machine; issues datapath commands and result loads.
// ----------------------------------------------------------------------------
module fmr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  fmr_pkg::dp_stat_t stat,
	output fmr_pkg::ctrl_cmd_t cmd
);
	import fmr_pkg::*;

	ctrl_state_t state_q, state_nxt;
	logic        accept;

	assign in_stall = (state_q == ST_DRAIN) || !stat.out_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT_START;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		if (state_q == ST_DRAIN) begin
			if (stat.out_free && stat.drain_done) state_nxt = ST_WAIT_START;
		end else if (accept) begin
			if (mode) begin
				if (state_q != ST_WAIT_START && stat.timed_out) state_nxt = ST_WAIT_START;
			end else if (stat.is_start) begin
				state_nxt = ST_LEN;
			end else begin
				unique case (state_q)
					ST_LEN:     state_nxt = stat.len_bad ? ST_WAIT_START : ST_PAYLOAD;
					ST_PAYLOAD: if (stat.printable && stat.payload_done) state_nxt = ST_CHK;
					ST_CHK:     state_nxt = stat.xor_ok ? ST_END : ST_WAIT_START;
					ST_END: begin
						if (stat.end_ok && stat.frame_ok && stat.cmd_found && !stat.data_empty)
							state_nxt = ST_DRAIN;
						else
							state_nxt = ST_WAIT_START;
					end
					default: state_nxt = state_q;
				endcase
			end
		end
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.out_code = STAT_OK;
		if (state_q == ST_DRAIN) begin
			if (stat.out_free) begin
				cmd.out_load = 1'b1;
				if (stat.drain_done) begin
					cmd.clr_frame = 1'b1;
				end else begin
					cmd.out_data   = 1'b1;
					cmd.drain_step = 1'b1;
				end
			end
		end else if (accept) begin
			if (mode) begin
				if (state_q != ST_WAIT_START) begin
					if (stat.timed_out) begin
						cmd.clr_frame = 1'b1;
						cmd.out_load  = 1'b1;
						cmd.out_code  = STAT_TIMEOUT;
					end else begin
						cmd.tick_inc = 1'b1;
					end
				end
			end else begin
				cmd.idle_clr = 1'b1;
				if (stat.is_start) begin
					cmd.clr_frame = 1'b1;
				end else begin
					unique case (state_q)
						ST_LEN: begin
							if (stat.len_bad) begin
								cmd.clr_frame = 1'b1;
								cmd.out_load  = 1'b1;
								cmd.out_code  = STAT_BAD_LEN;
							end else begin
								cmd.set_len = 1'b1;
							end
						end
						ST_PAYLOAD: begin
							if (stat.printable) begin
								cmd.take_byte = 1'b1;
							end else begin
								cmd.out_load = 1'b1;
								cmd.out_code = STAT_BAD_CHAR;
							end
						end
						ST_CHK: begin
							if (!stat.xor_ok) begin
								cmd.clr_frame = 1'b1;
								cmd.out_load  = 1'b1;
								cmd.out_code  = STAT_BAD_CHK;
							end
						end
						ST_END: begin
							priority if (!stat.end_ok || !stat.frame_ok) begin
								cmd.clr_frame = 1'b1;
								cmd.out_load  = 1'b1;
								cmd.out_code  = STAT_BAD_FMT;
							end else if (!stat.cmd_found) begin
								cmd.clr_frame = 1'b1;
								cmd.out_load  = 1'b1;
								cmd.out_code  = STAT_UNKNOWN_CMD;
							end else if (stat.data_empty) begin
								cmd.clr_frame = 1'b1;
								cmd.out_load  = 1'b1;
								cmd.out_code  = STAT_OK;
							end else begin
								cmd.out_load = 1'b0;
							end
						end
						default: cmd.out_load = 1'b0;
					endcase
				end
			end
		end
	end

endmodule

### rtl/fmr_dp.sv
// ----------------------------------------------------------------------------
// fmr_dp
// Frame datapath: config registers, payload parser, data store, result register.
// ----------------------------------------------------------------------------
module fmr_dp #(
	parameter int PAYLOAD_MAX = fmr_pkg::PAYLOAD_MAX_DEF,
	parameter int DATA_MAX    = fmr_pkg::DATA_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [fmr_pkg::CFG_W-1:0] cfg_data,
	input  logic [7:0]                rx_byte,
	input  logic                      out_stall,
	input  fmr_pkg::ctrl_cmd_t        cmd,
	output fmr_pkg::dp_stat_t         stat,
	output logic                      out_valid,
	output logic                      kind,
	output logic [2:0]                status,
	output logic [15:0]               sender_id,
	output logic [3:0]                command,
	output logic [7:0]                data_byte,
	output logic                      last
);
	import fmr_pkg::*;

	localparam int CW = $clog2(DATA_MAX);

	logic [7:0]  start_code_q, end_code_q;
	logic [5:0]  max_length_q;
	logic [15:0] timeout_ticks_q;

	logic [5:0]  frame_length_q, byte_index_q;
	logic [7:0]  running_xor_q;
	logic [15:0] idle_ticks_q;
	field_t      field_q;
	logic [15:0] id_value_q;
	logic        id_seen_q, id_bad_q;
	logic [NUM_CMDS-1:0] name_match_q, name_match_nxt;
	logic [3:0]  name_pos_q;
	logic [CW-1:0] data_count_q, drain_idx_q;
	logic [7:0]  data_store [DATA_MAX];

	logic        out_valid_q;
	logic [19:0] id_next;
	logic        is_digit, is_sep;
	logic        found;
	logic [3:0]  found_cmd;
	logic        store_wr;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q    <= START_CODE_RST;
			end_code_q      <= END_CODE_RST;
			max_length_q    <= MAX_LENGTH_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_START_CODE:    start_code_q    <= cfg_data[7:0];
				CFG_END_CODE:      end_code_q      <= cfg_data[7:0];
				CFG_MAX_LENGTH:    max_length_q    <= cfg_data[5:0];
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[15:0];
				default:           start_code_q    <= start_code_q;
			endcase
		end
	end

	assign is_digit = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
	assign is_sep   = (rx_byte == CHAR_SEP);
	assign id_next  = ({4'd0, id_value_q} << 3) + ({4'd0, id_value_q} << 1)
		+ {12'd0, rx_byte - CHAR_0};
	assign store_wr = cmd.take_byte && (field_q == FLD_DATA)
		&& (data_count_q < CW'(DATA_MAX - 1));

	always_comb begin
		name_match_nxt = name_match_q;
		for (int i = 0; i < NUM_CMDS; i++) begin
			if (name_pos_q >= cmd_len(3'(i)) || cmd_char(3'(i), name_pos_q[2:0]) != rx_byte)
				name_match_nxt[i] = 1'b0;
		end
	end

	always_comb begin
		found     = 1'b0;
		found_cmd = CMD_NONE;
		for (int i = 0; i < NUM_CMDS; i++) begin
			if (!found && name_match_q[i] && name_pos_q == cmd_len(3'(i))) begin
				found     = 1'b1;
				found_cmd = 4'(i);
			end
		end
	end

	// frame and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= '0;
			byte_index_q   <= '0;
			running_xor_q  <= '0;
			idle_ticks_q   <= '0;
			field_q        <= FLD_ID;
			id_value_q     <= '0;
			id_seen_q      <= 1'b0;
			id_bad_q       <= 1'b0;
			name_match_q   <= '1;
			name_pos_q     <= '0;
			data_count_q   <= '0;
			drain_idx_q    <= '0;
		end else if (cmd.clr_frame) begin
			frame_length_q <= '0;
			byte_index_q   <= '0;
			running_xor_q  <= '0;
			idle_ticks_q   <= '0;
			field_q        <= FLD_ID;
			id_value_q     <= '0;
			id_seen_q      <= 1'b0;
			id_bad_q       <= 1'b0;
			name_match_q   <= '1;
			name_pos_q     <= '0;
			data_count_q   <= '0;
			drain_idx_q    <= '0;
		end else begin
			if (cmd.idle_clr) idle_ticks_q <= '0;
			else if (cmd.tick_inc) idle_ticks_q <= idle_ticks_q + 16'd1;
			if (cmd.set_len) frame_length_q <= rx_byte[5:0];
			if (cmd.drain_step) drain_idx_q <= drain_idx_q + CW'(1);
			if (cmd.take_byte) begin
				running_xor_q <= running_xor_q ^ rx_byte;
				byte_index_q  <= byte_index_q + 6'd1;
				unique case (field_q)
					FLD_ID: begin
						if (is_sep) begin
							field_q <= FLD_CMD;
						end else if (is_digit) begin
							if (!id_bad_q) begin
								if (id_next > ID_MAX) id_bad_q <= 1'b1;
								else id_value_q <= id_next[15:0];
							end
							id_seen_q <= 1'b1;
						end else begin
							id_bad_q <= 1'b1;
						end
					end
					FLD_CMD: begin
						if (is_sep) begin
							field_q <= FLD_DATA;
						end else begin
							name_match_q <= name_match_nxt;
							if (name_pos_q < NAME_POS_MAX) name_pos_q <= name_pos_q + 4'd1;
						end
					end
					default: begin
						if (store_wr) data_count_q <= data_count_q + CW'(1);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_wr) data_store[data_count_q] <= rx_byte;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_data) begin
				kind      <= 1'b1;
				status    <= STAT_OK;
				sender_id <= id_value_q;
				command   <= found_cmd;
				data_byte <= data_store[drain_idx_q];
				last      <= 1'b0;
			end else begin
				kind      <= 1'b0;
				status    <= cmd.out_code;
				sender_id <= (cmd.out_code == STAT_OK || cmd.out_code == STAT_UNKNOWN_CMD)
					? id_value_q : 16'd0;
				command   <= (cmd.out_code == STAT_OK) ? found_cmd : CMD_NONE;
				data_byte <= 8'd0;
				last      <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;

	assign stat.is_start     = (rx_byte == start_code_q);
	assign stat.len_bad      = (rx_byte == 8'd0) || (rx_byte > {2'd0, max_length_q})
		|| (rx_byte > 8'(PAYLOAD_MAX));
	assign stat.printable    = (rx_byte >= CHAR_MIN) && (rx_byte <= CHAR_MAX);
	assign stat.payload_done = ({1'b0, byte_index_q} + 7'd1) >= {1'b0, frame_length_q};
	assign stat.xor_ok       = (running_xor_q == rx_byte);
	assign stat.end_ok       = (rx_byte == end_code_q);
	assign stat.timed_out    = (idle_ticks_q >= timeout_ticks_q);
	assign stat.frame_ok     = (field_q == FLD_DATA) && id_seen_q && !id_bad_q;
	assign stat.cmd_found    = found;
	assign stat.data_empty   = (data_count_q == '0);
	assign stat.drain_done   = (drain_idx_q == data_count_q);
	assign stat.out_free     = !out_valid_q || !out_stall;

endmodule

### rtl/framed_message_receiver.sv
// ----------------------------------------------------------------------------
// framed_message_receiver
// Start/length/payload/XOR/end deframer with id, command and data parsing.
// ----------------------------------------------------------------------------
// a result is registered and valid in the cycle after the input transfer that causes it,
// except the data items of a good frame, which are loaded in the drain state after its end code
// throughput: one input per cycle while the result register is free
// a good frame that stores n data bytes (at most DATA_MAX-1) gives n+1 results after the
// end code; input is stalled meanwhile
// reset: config to defaults, receiver waiting for a start code, no clear pass
module framed_message_receiver #(
	parameter int PAYLOAD_MAX = fmr_pkg::PAYLOAD_MAX_DEF,
	parameter int DATA_MAX    = fmr_pkg::DATA_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [fmr_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      mode,
	input  logic [7:0]                rx_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      kind,
	output logic [2:0]                status,
	output logic [15:0]               sender_id,
	output logic [3:0]                command,
	output logic [7:0]                data_byte,
	output logic                      last
);
	import fmr_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	fmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.stat     (stat),
		.cmd      (cmd)
	);

	fmr_dp #(
		.PAYLOAD_MAX (PAYLOAD_MAX),
		.DATA_MAX    (DATA_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_byte   (rx_byte),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.kind      (kind),
		.status    (status),
		.sender_id (sender_id),
		.command   (command),
		.data_byte (data_byte),
		.last      (last)
	);

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result register loaded while a result waits");

	// a timeout on a tick transfer shows up as a timeout status
	a_tick_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode && cmd.out_load)
		|=> (out_valid && status == STAT_TIMEOUT && !kind))
		else $error("tick produced a result other than timeout");

	// data items are never the final item
	a_data_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind) |-> (!last && status == STAT_OK))
		else $error("data item marked last or with error status");

	// error statuses other than unknown command carry no sender id and no command
	a_err_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STAT_OK && status != STAT_UNKNOWN_CMD)
		|-> (sender_id == 16'd0 && command == CMD_NONE))
		else $error("error status carries id or command");

endmodule
